// File: hdl/sahs_pkg.sv
// ----------------------------------------------------------------------------
// sahs_pkg
// Shared types and codes for the sparse array hashed store.
// ----------------------------------------------------------------------------
package sahs_pkg;

  localparam int unsigned INDEX_W  = 31;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // operation codes
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OOB  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic                      mode;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
  } out_item_t;

  // classified operation handed from front to back
  typedef struct packed {
    in_item_t item;
    logic     oob;
  } op_t;

  // one way of a bucket row
  typedef struct packed {
    logic                      valid;
    logic [INDEX_W-1:0]        key;
    logic signed [VALUE_W-1:0] data;
  } slot_t;

endpackage

// File: hdl/sahs_ram.sv
// ----------------------------------------------------------------------------
// sahs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sahs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/sahs_front.sv
// ----------------------------------------------------------------------------
// sahs_front
// Input handshake, bounds check and bucket number (index mod bucket count).
// ----------------------------------------------------------------------------
module sahs_front #(
  parameter int unsigned NUM_BUCKETS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  sahs_pkg::in_item_t                     in_data,
  input  logic                                   clearing,
  input  logic [sahs_pkg::INDEX_W-1:0]           array_length,
  input  logic                                   q_full,
  output logic                                   push,
  output sahs_pkg::op_t                          push_op,
  output logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] push_bucket
);

  localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  // floor(2^31 / N): quotient estimate is exact or one low
  localparam longint unsigned RECIP_L = 64'h8000_0000 / NUM_BUCKETS;
  localparam logic [31:0] RECIP = RECIP_L[31:0];
  localparam logic [sahs_pkg::INDEX_W-1:0] NB = sahs_pkg::INDEX_W'(NUM_BUCKETS);

  logic en;
  logic accept;

  logic                          v1_r, v1_nxt;
  sahs_pkg::op_t                 op1_r, op1_nxt;
  logic [62:0]                   prod1_r, prod1_nxt;
  logic                          v2_r, v2_nxt;
  sahs_pkg::op_t                 op2_r, op2_nxt;
  logic [sahs_pkg::INDEX_W-1:0]  qn2_r, qn2_nxt;

  logic [sahs_pkg::INDEX_W-1:0]  rem_est;
  logic [sahs_pkg::INDEX_W-1:0]  rem;

  assign en       = !(v2_r && q_full);
  assign in_stall = !en || clearing;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    v1_nxt    = v1_r;
    op1_nxt   = op1_r;
    prod1_nxt = prod1_r;
    v2_nxt    = v2_r;
    op2_nxt   = op2_r;
    qn2_nxt   = qn2_r;
    if (en) begin
      v1_nxt       = accept;
      op1_nxt.item = in_data;
      op1_nxt.oob  = (in_data.index >= array_length);
      prod1_nxt    = {32'd0, in_data.index} * {31'd0, RECIP};
      v2_nxt       = v1_r;
      op2_nxt      = op1_r;
      qn2_nxt      = prod1_r[61:31] * NB;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
    op1_r   <= op1_nxt;
    prod1_r <= prod1_nxt;
    op2_r   <= op2_nxt;
    qn2_r   <= qn2_nxt;
  end

  // remainder estimate lies below 2N
  assign rem_est = op2_r.item.index - qn2_r;
  assign rem     = (rem_est >= NB) ? rem_est - NB : rem_est;

  assign push        = v2_r && !q_full;
  assign push_op     = op2_r;
  assign push_bucket = rem[BW-1:0];

endmodule

// File: hdl/sahs_queue.sv
// ----------------------------------------------------------------------------
// sahs_queue
// Two-entry queue between classifier and table engine.
// ----------------------------------------------------------------------------
module sahs_queue #(
  parameter int unsigned WIDTH = 66
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count overflow");
`endif

endmodule

// File: hdl/sahs_back.sv
// ----------------------------------------------------------------------------
// sahs_back
// Table engine: clears the table, then reads a bucket row, updates it and
// writes it back, one item at a time; holds the result register.
// ----------------------------------------------------------------------------
module sahs_back #(
  parameter int unsigned NUM_BUCKETS     = 16,
  parameter int unsigned WAYS_PER_BUCKET = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  sahs_pkg::op_t       q_op,
  input  logic [(NUM_BUCKETS > 1 ? $clog2(NUM_BUCKETS) : 1)-1:0] q_bucket,
  output logic                pop,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_stall,
  output sahs_pkg::out_item_t out_data
);

  localparam int unsigned BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned WW    = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
  localparam int unsigned ROW_W = WAYS_PER_BUCKET * $bits(sahs_pkg::slot_t);
  localparam logic [BW-1:0] LAST_ROW = BW'(NUM_BUCKETS - 1);

  typedef enum logic [1:0] {S_CLEAR, S_ISSUE, S_EXEC} state_t;
  typedef sahs_pkg::slot_t [WAYS_PER_BUCKET-1:0] row_t;

  state_t              state_r, state_nxt;
  logic [BW-1:0]       clr_addr_r, clr_addr_nxt;
  sahs_pkg::op_t       op_r, op_nxt;
  logic [BW-1:0]       bucket_r, bucket_nxt;
  logic                out_valid_r, out_valid_nxt;
  sahs_pkg::out_item_t out_item_r, out_item_nxt;

  logic                ram_we;
  logic [BW-1:0]       ram_waddr;
  logic [ROW_W-1:0]    ram_wdata;
  logic                ram_re;
  logic [ROW_W-1:0]    ram_rdata;

  row_t                row;
  row_t                new_row;
  logic [WAYS_PER_BUCKET-1:0] hit_vec;
  logic [WAYS_PER_BUCKET-1:0] free_vec;
  logic [WW-1:0]       hit_way;
  logic [WW-1:0]       free_way;
  logic                any_hit;
  logic                any_free;
  sahs_pkg::out_item_t result;
  logic                slot_free;

  sahs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (q_bucket),
    .rdata (ram_rdata)
  );

  // way match and lowest free way
  always_comb begin
    row      = row_t'(ram_rdata);
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
      hit_vec[w]  = row[w].valid && (row[w].key == op_r.item.index);
      free_vec[w] = !row[w].valid;
    end
    for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WW'(w);
      end
      if (free_vec[w]) begin
        free_way = WW'(w);
      end
    end
    any_hit  = |hit_vec;
    any_free = |free_vec;
  end

  // row update and result
  always_comb begin
    new_row           = row;
    result.read_value = '0;
    result.status     = sahs_pkg::STAT_OK;
    if (op_r.oob) begin
      result.status = sahs_pkg::STAT_OOB;
    end else if (op_r.item.mode == sahs_pkg::MODE_READ) begin
      if (any_hit) begin
        result.read_value = row[hit_way].data;
      end
    end else if (op_r.item.value == '0) begin
      if (any_hit) begin
        new_row[hit_way].valid = 1'b0;
      end
    end else if (any_hit) begin
      new_row[hit_way].data = op_r.item.value;
    end else if (any_free) begin
      new_row[free_way].valid = 1'b1;
      new_row[free_way].key   = op_r.item.index;
      new_row[free_way].data  = op_r.item.value;
    end else begin
      result.status = sahs_pkg::STAT_FULL;
    end
  end

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    op_nxt        = op_r;
    bucket_nxt    = bucket_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = bucket_r;
    ram_wdata     = ROW_W'(new_row);
    ram_re        = 1'b0;
    pop           = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ROW) begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (q_valid) begin
          pop        = 1'b1;
          ram_re     = 1'b1;
          op_nxt     = q_op;
          bucket_nxt = q_bucket;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          ram_we        = !op_r.oob && (op_r.item.mode == sahs_pkg::MODE_WRITE);
          out_valid_nxt = 1'b1;
          out_item_nxt  = result;
          state_nxt     = S_ISSUE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    bucket_r   <= bucket_nxt;
    out_item_r <= out_item_nxt;
  end

  assign clearing  = (state_r == S_CLEAR);
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

`ifndef SYNTHESIS
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> $onehot0(hit_vec)) else $error("index held in two ways");
  a_exec_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == S_EXEC) else $error("pop without bucket lookup");
  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status == sahs_pkg::STAT_OOB |-> out_item_r.read_value == '0)
    else $error("rejected access returned data");
`endif

endmodule

// File: hdl/sparse_array_hashed_store_unit.sv
// ----------------------------------------------------------------------------
// sparse_array_hashed_store_unit
// Sparse array in a set-associative table of NUM_BUCKETS x WAYS_PER_BUCKET.
// ----------------------------------------------------------------------------
// Each input beat reads or writes one array position and gives exactly one
// result beat. Position p lives in bucket p mod NUM_BUCKETS, in any of its
// ways; absent positions read as zero and writing zero drops the entry.
// Positions at or beyond array_length return status out-of-bounds; a new
// nonzero write to a bucket with no free way returns bucket-full and leaves
// the table as it was. After reset the table is swept clear, one bucket row
// per cycle; in_stall is high during the sweep. The table engine reads
// the bucket row from the single RAM, then updates it and writes it back,
// and takes a new item only when it is through with the last one. The
// front end (bounds check and a two-stage reciprocal multiply for the
// bucket number) feeds a two-entry queue, so input beats keep flowing
// while a result waits on out_stall, until the queue is full. array_length
// is written through the cfg port; the user must write it only while the
// unit is idle, which the block itself does not enforce; cfg_ready is
// always high.
// ----------------------------------------------------------------------------
module sparse_array_hashed_store_unit #(
  parameter int unsigned NUM_BUCKETS     = 16,
  parameter int unsigned WAYS_PER_BUCKET = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // item input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  sahs_pkg::in_item_t           in_data,
  // results
  output logic                         out_valid,
  input  logic                         out_stall,
  output sahs_pkg::out_item_t          out_data,
  // array_length register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [sahs_pkg::INDEX_W-1:0] cfg_data
);

  localparam int unsigned BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned Q_W = $bits(sahs_pkg::op_t) + BW;

  logic [sahs_pkg::INDEX_W-1:0] array_length_r, array_length_nxt;

  logic                clearing;
  logic                q_full;
  logic                push;
  sahs_pkg::op_t       push_op;
  logic [BW-1:0]       push_bucket;
  logic                pop;
  logic                q_valid;
  logic [Q_W-1:0]      q_rdata;
  sahs_pkg::op_t       q_op;
  logic [BW-1:0]       q_bucket;

  // config register: always ready; the user must write it only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  always_comb begin
    array_length_nxt = array_length_r;
    if (cfg_valid && cfg_ready) begin
      array_length_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      array_length_r <= '0;
    end else begin
      array_length_r <= array_length_nxt;
    end
  end

  // front end: handshake, bounds check, bucket number
  sahs_front #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .clearing     (clearing),
    .array_length (array_length_r),
    .q_full       (q_full),
    .push         (push),
    .push_op      (push_op),
    .push_bucket  (push_bucket)
  );

  // decoupling queue
  sahs_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({push_op, push_bucket}),
    .full  (q_full),
    .pop   (pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  assign q_op     = q_rdata[Q_W-1:BW];
  assign q_bucket = q_rdata[BW-1:0];

  // back end: table read-modify-write and result register
  sahs_back #(
    .NUM_BUCKETS     (NUM_BUCKETS),
    .WAYS_PER_BUCKET (WAYS_PER_BUCKET)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_bucket  (q_bucket),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> in_stall) else $error("input taken during table sweep");
`endif

endmodule
